[rtl/sorted_index_binary_lookup_assert.svh]
// Assertion macros shared by the sorted index lookup RTL.
// No dependencies; included inside module bodies.
`ifndef SORTED_INDEX_BINARY_LOOKUP_ASSERT_SVH
`define SORTED_INDEX_BINARY_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define SIL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sil assertion failed");

// Next-cycle implication, disabled in reset
`define SIL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sil assertion failed");

`endif

[rtl/sil_pkg.sv]
// Types and constants for the sorted index lookup block.
// No dependencies; used by every module in rtl/.
package sil_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;

    localparam int COUNT_W  = 13;
    localparam int INDEX_W  = 12;
    localparam int KEY_W    = 64;
    localparam int DIMS_W   = 32;
    localparam int WORD_W   = 32;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic       KIND_WRITE  = 1'b0;
    localparam logic       KIND_LOOKUP = 1'b1;
    localparam logic       REG_SEARCH_COUNT = 1'b0;
    localparam logic [31:0] FORMAT_VQ = 32'd1;

    typedef struct packed {
        logic        kind;
        logic [11:0] entry_index;
        logic [15:0] collection;
        logic [15:0] palette;
        logic [15:0] bitmap;
        logic [15:0] variant;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] format;
        logic [31:0] payload_offset;
        logic [31:0] payload_size;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [11:0] position;
        logic [31:0] match_offset;
        logic [31:0] match_size;
    } out_item_t;

    // one table row
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DIMS_W-1:0] dims;
        logic [WORD_W-1:0] format;
        logic [WORD_W-1:0] offset;
        logic [WORD_W-1:0] size;
    } entry_t;

    // compare unit status
    typedef struct packed {
        logic lt;
        logic eq;
        logic hit;
    } cmp_status_t;

endpackage

[rtl/sil_table.sv]
// Index table memory: one write port, one read port with registered data.
// Depends on sil_pkg.
module sil_table #(
    parameter int DEPTH = sil_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  sil_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output sil_pkg::entry_t rd_data
);
    import sil_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sil_cmp.sv]
// Shared key compare unit: orders the probed key against the request key
// and checks the full match conditions. Depends on sil_pkg.
module sil_cmp (
    input  sil_pkg::entry_t                   entry,
    input  logic [sil_pkg::KEY_W-1:0]         req_key,
    input  logic [sil_pkg::DIMS_W-1:0]        req_dims,
    output sil_pkg::cmp_status_t              status
);
    import sil_pkg::*;

    always_comb
    begin
        status.lt  = entry.key < req_key;
        status.eq  = entry.key == req_key;
        status.hit = status.eq && (entry.dims == req_dims) &&
                     (entry.format == FORMAT_VQ) && (entry.size != '0);
    end

endmodule

[rtl/sil_seq.sv]
// Search sequencer: accepts requests, drives the table ports, steps the
// lower-bound search and holds the result register. Depends on sil_pkg.
module sil_seq #(
    parameter int DEPTH = sil_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  sil_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output sil_pkg::out_item_t            out_data,
    input  logic [sil_pkg::COUNT_W-1:0]   search_count,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output sil_pkg::entry_t               wr_data,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr,
    input  sil_pkg::entry_t               rd_data,
    output logic [sil_pkg::KEY_W-1:0]     req_key,
    output logic [sil_pkg::DIMS_W-1:0]    req_dims,
    input  sil_pkg::cmp_status_t          status
);
    import sil_pkg::*;

    `include "sorted_index_binary_lookup_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_WAIT   = 4'b0100,
        S_CHECK  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     low_reg, low_next;
    logic [CW-1:0]     high_reg, high_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              in_range_reg, in_range_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DIMS_W-1:0] dims_reg, dims_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              accept;
    logic              out_free;
    logic [CW-1:0]     mid_calc;
    logic [CW-1:0]     count_sat;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign mid_calc = low_reg + ((high_reg - low_reg) >> 1);
    assign count_sat = (32'(search_count) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(search_count);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign req_key   = key_reg;
    assign req_dims  = dims_reg;

    // write port straight from the request
    assign wr_en   = accept && (in_data.kind == KIND_WRITE) &&
                     (32'(in_data.entry_index) < 32'(DEPTH));
    assign wr_addr = AW'(in_data.entry_index);
    always_comb
    begin
        wr_data.key    = {in_data.collection, in_data.palette, in_data.bitmap,
                          in_data.variant};
        wr_data.dims   = {in_data.width, in_data.height};
        wr_data.format = in_data.format;
        wr_data.offset = in_data.payload_offset;
        wr_data.size   = in_data.payload_size;
    end

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        count_next     = count_reg;
        in_range_next  = in_range_reg;
        key_next       = key_reg;
        dims_next      = dims_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = AW'(mid_calc);

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_data.kind == KIND_LOOKUP))
                begin
                    key_next   = wr_data.key;
                    dims_next  = wr_data.dims;
                    low_next   = '0;
                    high_next  = count_sat;
                    count_next = count_sat;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (low_reg < high_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(mid_calc);
                    mid_next   = mid_calc;
                    state_next = S_WAIT;
                end
                else
                begin
                    // lower bound settled, fetch it for the final check
                    in_range_next = low_reg < count_reg;
                    rd_en         = low_reg < count_reg;
                    rd_addr       = AW'(low_reg);
                    state_next    = S_CHECK;
                end
            end
            S_WAIT:
            begin
                if (status.lt)
                begin
                    low_next = mid_reg + CW'(1);
                end
                else
                begin
                    high_next = mid_reg;
                end
                state_next = S_SEARCH;
            end
            S_CHECK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (in_range_reg && status.hit)
                    begin
                        out_data_next.found        = 1'b1;
                        out_data_next.position     = INDEX_W'(low_reg);
                        out_data_next.match_offset = rd_data.offset;
                        out_data_next.match_size   = rd_data.size;
                    end
                    else
                    begin
                        out_data_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg      <= low_next;
        high_reg     <= high_next;
        mid_reg      <= mid_next;
        count_reg    <= count_next;
        in_range_reg <= in_range_next;
        key_reg      <= key_next;
        dims_reg     <= dims_next;
        out_data_reg <= out_data_next;
    end

    `SIL_ASSERT_IMP(a_wait_after_search, clk, rst_n,
        state_reg == S_WAIT, $past(state_reg) == S_SEARCH)
    `SIL_ASSERT_IMP(a_bounds_ordered, clk, rst_n,
        state_reg != S_IDLE, low_reg <= high_reg && high_reg <= count_reg)
    `SIL_ASSERT_IMP(a_count_in_depth, clk, rst_n,
        state_reg != S_IDLE, count_reg <= CW'(DEPTH))
    `SIL_ASSERT_NXT(a_result_from_check, clk, rst_n,
        !out_valid_reg, !out_valid_reg || $past(state_reg) == S_CHECK)

endmodule

[rtl/sorted_index_binary_lookup.sv]
// Sorted index lookup top level: APB count register, index table, compare unit and
// sequencer (depends on sil_pkg, sil_table, sil_cmp, sil_seq). A write request stores
// one entry and the input stays open. A lookup request runs a lower-bound search
// over the first min(count, TABLE_DEPTH) entries with one shared compare unit: each
// probe is a table read and then a compare, and up to ceil(log2(n+1)) probes are
// needed (13 for 4096 entries); then the landing entry is fetched and checked.
// in_stall stays high from the accepted lookup until its result is taken into the
// output register, so no new request is accepted while a lookup is in flight.
// A result still held by out_stall keeps the next lookup in its check state.
module sorted_index_binary_lookup #(
    parameter int TABLE_DEPTH = sil_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  sil_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output sil_pkg::out_item_t            out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sil_pkg::PADDR_W-1:0]   paddr,
    input  logic [sil_pkg::PDATA_W-1:0]   pwdata,
    output logic [sil_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import sil_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [COUNT_W-1:0] search_count_reg, search_count_next;
    logic               reg_sel;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    entry_t             rd_data;
    logic [KEY_W-1:0]   req_key;
    logic [DIMS_W-1:0]  req_dims;
    cmp_status_t        status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_SEARCH_COUNT);
    assign prdata  = reg_sel ? PDATA_W'(search_count_reg) : '0;

    always_comb
    begin
        search_count_next = search_count_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            search_count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_count_reg <= '0;
        end
        else
        begin
            search_count_reg <= search_count_next;
        end
    end

    sil_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sil_cmp u_cmp (
        .entry    (rd_data),
        .req_key  (req_key),
        .req_dims (req_dims),
        .status   (status)
    );

    sil_seq #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .search_count (search_count_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .req_key      (req_key),
        .req_dims     (req_dims),
        .status       (status)
    );

endmodule
